/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/bmis_pkg.sv */
package bmis_pkg;

    localparam int BYTE_W        = 8;
    localparam int NIB_W         = 4;
    localparam int REG_COUNT     = 16;
    localparam int REG_IDX_W     = 4;
    localparam int MEM_DEPTH_DEF = 256;

    // Item operations.
    localparam logic [1:0] OPN_LOAD     = 2'd0;
    localparam logic [1:0] OPN_EXEC     = 2'd1;
    localparam logic [1:0] OPN_READ_MEM = 2'd2;
    localparam logic [1:0] OPN_READ_REG = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_ALREADY = 2'd3;

    // Instruction opcodes.
    localparam logic [3:0] OPC_LDM   = 4'h1;
    localparam logic [3:0] OPC_LDI   = 4'h2;
    localparam logic [3:0] OPC_STORE = 4'h3;
    localparam logic [3:0] OPC_MOVE  = 4'h4;
    localparam logic [3:0] OPC_ADD   = 4'h5;
    localparam logic [3:0] OPC_JEQ   = 4'hB;
    localparam logic [3:0] OPC_HALT  = 4'hC;

    typedef enum logic [4:0] {
        U_IDLE,
        U_LOAD,
        U_RDMEM0,
        U_RDMEM1,
        U_RDREG,
        U_FETCH0,
        U_FETCH1,
        U_DECODE,
        U_LDM0,
        U_LDM1,
        U_LDI,
        U_STORE,
        U_MOVE,
        U_ADD0,
        U_ADD1,
        U_BR0,
        U_BR1,
        U_HALTC,
        U_FAULT,
        U_ALREADY
    } ustep_t;

    typedef enum logic [1:0] {MA_PC, MA_PC1, MA_IN, MA_LO} ma_sel_t;
    typedef enum logic [1:0] {MW_NONE, MW_IN, MW_STORE} mw_t;
    typedef enum logic [2:0] {RS_IN, RS_R, RS_X, RS_Y, RS_ZERO, RS_SCR} rs_t;
    typedef enum logic {WA_R, WA_Y} wa_t;
    typedef enum logic [1:0] {WD_MEM, WD_LO, WD_RD, WD_SUM} wd_t;
    typedef enum logic [1:0] {PC_HOLD, PC_ADV, PC_BRANCH} pcop_t;
    typedef enum logic [2:0] {
        RES_NONE, RES_OK, RES_READ_MEM, RES_READ_REG, RES_STORE,
        RES_HALT_C, RES_HALT_BAD, RES_ALREADY
    } res_t;
    typedef enum logic [1:0] {SQ_GOTO, SQ_DISPATCH, SQ_END} seq_t;

    // One control word of the microprogram.
    typedef struct packed {
        ma_sel_t ma;
        logic    mem_rd;
        mw_t     mw;
        logic    ld_hi;
        logic    ld_lo;
        rs_t     rs;
        logic    ld_a;
        logic    reg_we;
        wa_t     wa;
        wd_t     wd;
        pcop_t   pcop;
        res_t    res;
        seq_t    seq;
        ustep_t  nxt;
    } ctrl_t;

    // First microstep of an item.
    function automatic ustep_t entry_step(logic [1:0] operation, logic halted);
        ustep_t s;
        s = U_IDLE;
        unique case (operation)
            OPN_LOAD:     s = U_LOAD;
            OPN_EXEC:     s = halted ? U_ALREADY : U_FETCH0;
            OPN_READ_MEM: s = U_RDMEM0;
            OPN_READ_REG: s = U_RDREG;
            default:      s = U_IDLE;
        endcase
        return s;
    endfunction

    // Jump table on the opcode nibble.
    function automatic ustep_t dispatch_step(logic [3:0] opc);
        ustep_t s;
        s = U_FAULT;
        unique case (opc)
            OPC_LDM:   s = U_LDM0;
            OPC_LDI:   s = U_LDI;
            OPC_STORE: s = U_STORE;
            OPC_MOVE:  s = U_MOVE;
            OPC_ADD:   s = U_ADD0;
            OPC_JEQ:   s = U_BR0;
            OPC_HALT:  s = U_HALTC;
            default:   s = U_FAULT;
        endcase
        return s;
    endfunction

    // The microprogram itself.
    function automatic ctrl_t ucode(ustep_t step);
        ctrl_t cw;
        cw = '0;
        cw.seq = SQ_END;
        unique case (step)
            U_IDLE: cw.seq = SQ_GOTO;
            U_LOAD:
            begin
                cw.ma  = MA_IN;
                cw.mw  = MW_IN;
                cw.res = RES_OK;
            end
            U_RDMEM0:
            begin
                cw.ma     = MA_IN;
                cw.mem_rd = 1'b1;
                cw.seq    = SQ_GOTO;
                cw.nxt    = U_RDMEM1;
            end
            U_RDMEM1: cw.res = RES_READ_MEM;
            U_RDREG:
            begin
                cw.rs  = RS_IN;
                cw.res = RES_READ_REG;
            end
            U_FETCH0:
            begin
                cw.ma     = MA_PC;
                cw.mem_rd = 1'b1;
                cw.seq    = SQ_GOTO;
                cw.nxt    = U_FETCH1;
            end
            U_FETCH1:
            begin
                cw.ld_hi  = 1'b1;
                cw.ma     = MA_PC1;
                cw.mem_rd = 1'b1;
                cw.seq    = SQ_GOTO;
                cw.nxt    = U_DECODE;
            end
            U_DECODE:
            begin
                cw.ld_lo = 1'b1;
                cw.seq   = SQ_DISPATCH;
            end
            U_LDM0:
            begin
                cw.ma     = MA_LO;
                cw.mem_rd = 1'b1;
                cw.seq    = SQ_GOTO;
                cw.nxt    = U_LDM1;
            end
            U_LDM1:
            begin
                cw.reg_we = 1'b1;
                cw.wa     = WA_R;
                cw.wd     = WD_MEM;
                cw.pcop   = PC_ADV;
                cw.res    = RES_OK;
            end
            U_LDI:
            begin
                cw.reg_we = 1'b1;
                cw.wa     = WA_R;
                cw.wd     = WD_LO;
                cw.pcop   = PC_ADV;
                cw.res    = RES_OK;
            end
            U_STORE:
            begin
                cw.rs   = RS_SCR;
                cw.ma   = MA_LO;
                cw.mw   = MW_STORE;
                cw.pcop = PC_ADV;
                cw.res  = RES_STORE;
            end
            U_MOVE:
            begin
                cw.rs     = RS_X;
                cw.reg_we = 1'b1;
                cw.wa     = WA_Y;
                cw.wd     = WD_RD;
                cw.pcop   = PC_ADV;
                cw.res    = RES_OK;
            end
            U_ADD0:
            begin
                cw.rs   = RS_X;
                cw.ld_a = 1'b1;
                cw.seq  = SQ_GOTO;
                cw.nxt  = U_ADD1;
            end
            U_ADD1:
            begin
                cw.rs     = RS_Y;
                cw.reg_we = 1'b1;
                cw.wa     = WA_R;
                cw.wd     = WD_SUM;
                cw.pcop   = PC_ADV;
                cw.res    = RES_OK;
            end
            U_BR0:
            begin
                cw.rs   = RS_ZERO;
                cw.ld_a = 1'b1;
                cw.seq  = SQ_GOTO;
                cw.nxt  = U_BR1;
            end
            U_BR1:
            begin
                cw.rs   = RS_R;
                cw.pcop = PC_BRANCH;
                cw.res  = RES_OK;
            end
            U_HALTC:   cw.res = RES_HALT_C;
            U_FAULT:   cw.res = RES_HALT_BAD;
            U_ALREADY: cw.res = RES_ALREADY;
            default:   cw.seq = SQ_END;
        endcase
        return cw;
    endfunction

endpackage

/* hw/rtl/bmis_in_if.sv */
interface bmis_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] address;
    logic [7:0] data;

    modport source (output valid, output operation, output address, output data, input ready);
    modport sink (input valid, input operation, input address, input data, output ready);
endinterface

/* hw/rtl/bmis_out_if.sv */
interface bmis_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] program_counter;
    logic [7:0] read_value;
    logic       screen_valid;
    logic [7:0] screen_value;

    modport source (
        output valid, output status, output program_counter, output read_value,
        output screen_valid, output screen_value, input ready
    );
    modport sink (
        input valid, input status, input program_counter, input read_value,
        input screen_valid, input screen_value, output ready
    );
endinterface

/* hw/rtl/bmis_ram.sv */
// Single-port byte memory with registered read data. The byte address is
// folded into the memory depth by four conditional subtractions.
module bmis_ram #(
    parameter int MEM_DEPTH = bmis_pkg::MEM_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic                          wr_en,
    input  logic [bmis_pkg::BYTE_W-1:0]   addr,
    input  logic [bmis_pkg::BYTE_W-1:0]   wdata,
    output logic [bmis_pkg::BYTE_W-1:0]   rdata
);
    import bmis_pkg::*;

    localparam int IDX_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [11:0]       fold;
    logic [IDX_W-1:0]  idx;

    always_comb
    begin
        fold = {4'b0, addr};
        for (int k = 3; k >= 0; k--)
        begin
            if (fold >= 12'(MEM_DEPTH << k))
            begin
                fold = fold - 12'(MEM_DEPTH << k);
            end
        end
        idx = fold[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[idx];
        end
    end
endmodule

/* hw/rtl/byte_machine_instruction_step_core.sv */
// Byte machine core: an 8-bit teaching computer that runs one request item
// at a time. The req channel carries an operation (load a memory byte,
// execute one instruction, read memory, read a register), an address and a
// data byte; the rsp channel returns one item per request with the status,
// the program counter after the item, any read byte and any screen output.
// Control comes from a microprogram in the package: a step counter walks
// control words that drive one memory port, the register file and the pc.
// An execute makes two fetch reads through the single memory port and a
// decode step, then runs one step for a halt, a load immediate, a store or
// a register copy and two for a memory load, an add or a branch; a load, a
// register read or an execute while halted has one step, a memory read two.
// A new item is accepted in the cycle after the previous one has finished,
// even while its response still sits in the output register.
// If the receiver stalls with a response pending, the next item runs up to
// its final step and waits there, with no state change, until the output
// register frees. Reset clears the registers, pc, halt flag and the output
// valid flag; memory contents are undefined until written.
module byte_machine_instruction_step_core #(
    parameter int MEM_DEPTH = bmis_pkg::MEM_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bmis_in_if.sink   req,
    bmis_out_if.source rsp
);
    import bmis_pkg::*;

    // The second instruction byte lives at pc + 1 taken before the 8-bit
    // wrap, so at pc 255 it is memory slot 256 folded into the depth.
    localparam logic [BYTE_W-1:0] PC_TOP_SLOT = BYTE_W'((1 << BYTE_W) % MEM_DEPTH);

    // Sequencer state and the control word of the current step.
    ustep_t upc_reg, upc_next;
    ctrl_t  cw;

    // Machine state.
    logic [BYTE_W-1:0] regs_reg [REG_COUNT];
    logic [BYTE_W-1:0] pc_reg, pc_next;
    logic              halted_reg;

    // Item and instruction holding registers (payload only).
    logic [BYTE_W-1:0] addr_in_reg;
    logic [BYTE_W-1:0] data_in_reg;
    logic [BYTE_W-1:0] hi_reg;
    logic [BYTE_W-1:0] lo_reg;
    logic [BYTE_W-1:0] a_reg;

    // Output register.
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [BYTE_W-1:0] out_pc_reg;
    logic [BYTE_W-1:0] out_read_reg;
    logic              out_scr_valid_reg;
    logic [BYTE_W-1:0] out_scr_value_reg;

    logic              in_fire;
    logic              out_free;
    logic              commit;
    logic              finish;
    logic              r_is_zero;
    logic [REG_IDX_W-1:0] rd_idx;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [BYTE_W-1:0] rd_val;
    logic [BYTE_W-1:0] wr_val;
    logic [BYTE_W-1:0] pc_plus2;
    logic [BYTE_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    logic              mem_rd;
    logic              mem_we;
    logic [1:0]        res_status;
    logic [BYTE_W-1:0] res_read;
    logic              res_scr_valid;

    bmis_ram #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .rd_en (mem_rd),
        .wr_en (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req.ready = (upc_reg == U_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.program_counter = out_pc_reg;
    assign rsp.read_value      = out_read_reg;
    assign rsp.screen_valid    = out_scr_valid_reg;
    assign rsp.screen_value    = out_scr_value_reg;

    // Decode of the current step and the datapath around it.
    always_comb
    begin
        cw        = ucode(upc_reg);
        finish    = (cw.res != RES_NONE);
        // A final step only takes effect once its response has somewhere to go.
        commit    = (upc_reg != U_IDLE) && (!finish || out_free);
        r_is_zero = (hi_reg[NIB_W-1:0] == '0);
        pc_plus2  = pc_reg + BYTE_W'(2);

        case (cw.rs)
            RS_IN:   rd_idx = addr_in_reg[NIB_W-1:0];
            RS_R:    rd_idx = hi_reg[NIB_W-1:0];
            RS_X:    rd_idx = lo_reg[BYTE_W-1:NIB_W];
            RS_Y:    rd_idx = lo_reg[NIB_W-1:0];
            RS_SCR:  rd_idx = r_is_zero ? lo_reg[BYTE_W-1:NIB_W] : hi_reg[NIB_W-1:0];
            default: rd_idx = '0;
        endcase
        rd_val = regs_reg[rd_idx];

        wr_idx = (cw.wa == WA_Y) ? lo_reg[NIB_W-1:0] : hi_reg[NIB_W-1:0];
        case (cw.wd)
            WD_MEM:  wr_val = mem_rdata;
            WD_LO:   wr_val = lo_reg;
            WD_RD:   wr_val = rd_val;
            default: wr_val = a_reg + rd_val;
        endcase

        case (cw.ma)
            MA_PC:   mem_addr = pc_reg;
            MA_PC1:  mem_addr = (pc_reg == '1) ? PC_TOP_SLOT : pc_reg + BYTE_W'(1);
            MA_IN:   mem_addr = addr_in_reg;
            default: mem_addr = lo_reg;
        endcase
        mem_rd    = commit && cw.mem_rd;
        mem_we    = commit && ((cw.mw == MW_IN) || ((cw.mw == MW_STORE) && !r_is_zero));
        mem_wdata = (cw.mw == MW_IN) ? data_in_reg : rd_val;

        // Branch compares the named register with R0, held in a_reg.
        case (cw.pcop)
            PC_ADV:    pc_next = pc_plus2;
            PC_BRANCH: pc_next = (rd_val == a_reg) ? lo_reg : pc_plus2;
            default:   pc_next = pc_reg;
        endcase

        res_status    = ST_OK;
        res_read      = '0;
        res_scr_valid = 1'b0;
        case (cw.res)
            RES_READ_MEM: res_read = mem_rdata;
            RES_READ_REG: res_read = rd_val;
            RES_STORE:    res_scr_valid = r_is_zero;
            RES_HALT_C:   res_status = ST_HALT;
            RES_HALT_BAD: res_status = ST_FAULT;
            RES_ALREADY:  res_status = ST_ALREADY;
            default:      res_status = ST_OK;
        endcase
    end

    // Next microstep.
    always_comb
    begin
        upc_next = upc_reg;
        if (upc_reg == U_IDLE)
        begin
            if (in_fire)
            begin
                upc_next = entry_step(req.operation, halted_reg);
            end
        end
        else if (commit)
        begin
            unique case (cw.seq)
                SQ_GOTO:     upc_next = cw.nxt;
                SQ_DISPATCH: upc_next = dispatch_step(hi_reg[BYTE_W-1:NIB_W]);
                default:     upc_next = U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // Architectural state and the response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit && cw.reg_we)
            begin
                regs_reg[wr_idx] <= wr_val;
            end
            if (commit)
            begin
                pc_reg <= pc_next;
            end
            if (commit && ((cw.res == RES_HALT_C) || (cw.res == RES_HALT_BAD)))
            begin
                halted_reg <= 1'b1;
            end
            if (commit && finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_in_reg <= req.address;
            data_in_reg <= req.data;
        end
        if (commit && cw.ld_hi)
        begin
            hi_reg <= mem_rdata;
        end
        if (commit && cw.ld_lo)
        begin
            lo_reg <= mem_rdata;
        end
        if (commit && cw.ld_a)
        begin
            a_reg <= rd_val;
        end
        if (commit && finish)
        begin
            out_status_reg    <= res_status;
            out_pc_reg        <= pc_next;
            out_read_reg      <= res_read;
            out_scr_valid_reg <= res_scr_valid;
            out_scr_value_reg <= res_scr_valid ? rd_val : '0;
        end
    end
endmodule

/* hw/rtl/bmis_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the byte machine core.
module bmis_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [7:0] program_counter,
    input logic [7:0] read_value,
    input logic       screen_valid,
    input logic [7:0] screen_value
);
    import bmis_pkg::*;

    // A stalled response keeps its contents.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(program_counter)
        && $stable(read_value) && $stable(screen_valid) && $stable(screen_value))

    // Items are worked one at a time, so the core is busy after taking one.
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // Screen output comes with an OK status and a zero read byte, as from a store.
    `ASSERT_SAME(a_screen_ok, clk, rst_n, out_valid && screen_valid,
        (status == ST_OK) && (read_value == 8'd0))

    // Everything except a screen output reports a zero screen byte.
    `ASSERT_SAME(a_screen_zero, clk, rst_n, out_valid && !screen_valid,
        screen_value == 8'd0)
endmodule

bind byte_machine_instruction_step_core bmis_checker u_bmis_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .program_counter (rsp.program_counter),
    .read_value      (rsp.read_value),
    .screen_valid    (rsp.screen_valid),
    .screen_value    (rsp.screen_value)
);
